// File: rtl/alid_pkg.sv
// ----------------------------------------------------------------------------
// alid_pkg
// Shared codes and sizes for the array list insert/delete block.
// ----------------------------------------------------------------------------
package alid_pkg;

    // Default list depth
    localparam int DEPTH_DEF = 16;

    // Fixed field widths
    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;

    // Command codes
    localparam logic [FUNC_W-1:0] FN_APPEND   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DEL_AT   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_LAST = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

endpackage

// File: rtl/alid_cmd_if.sv
// ----------------------------------------------------------------------------
// alid_cmd_if
// Command channel: one list operation per beat.
// ----------------------------------------------------------------------------
interface alid_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [alid_pkg::FUNC_W-1:0]    func;
    logic [alid_pkg::BYTE_W-1:0]    data_byte;
    logic [alid_pkg::POS_W-1:0]     position;

    modport source (output valid, output func, output data_byte, output position,
                    input ready);
    modport sink   (input valid, input func, input data_byte, input position,
                    output ready);
endinterface

// File: rtl/alid_rsp_if.sv
// ----------------------------------------------------------------------------
// alid_rsp_if
// Response channel: status beat or one list entry per beat.
// ----------------------------------------------------------------------------
interface alid_rsp_if #(
    parameter int DEPTH = alid_pkg::DEPTH_DEF
);
    localparam int LEN_W = $clog2(DEPTH + 1);

    logic                           valid;
    logic                           ready;
    logic [alid_pkg::STATUS_W-1:0]  status;
    logic [LEN_W-1:0]               length;
    logic [alid_pkg::BYTE_W-1:0]    entry;
    logic                           entry_valid;
    logic                           last;

    modport source (output valid, output status, output length, output entry,
                    output entry_valid, output last, input ready);
    modport sink   (input valid, input status, input length, input entry,
                    input entry_valid, input last, output ready);
endinterface

// File: rtl/alid_ram.sv
// ----------------------------------------------------------------------------
// alid_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module alid_ram #(
    parameter int WIDTH = alid_pkg::BYTE_W,
    parameter int DEPTH = alid_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/array_list_insert_delete.sv
// ----------------------------------------------------------------------------
// array_list_insert_delete
// Ordered byte list in a RAM with append, insert, delete and delete-last.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command per beat (func, data_byte, position). o_rsp
//   returns either one status beat (failure, or success leaving the list
//   empty, entry_valid low) or the whole list, one entry per beat in order,
//   with last set on the final beat. The o_rsp instance must be built with
//   the same DEPTH as this module.
//   One command is handled at a time; i_cmd.ready is high only while idle.
//   Timing is set by the single RAM port pair and the shared index counter:
//     - a failing command gives its beat in the cycle after acceptance;
//     - an insert shifts (count - position) entries and a delete shifts
//       (count - position - 1), each by a read state then a write state;
//     - the dump moves each entry through read, load and output states.
//   A stalled receiver holds the current beat; the sequencer waits on it.
//   Reset empties the list; no clearing pass is needed since only entries
//   below the count are ever used.
// ----------------------------------------------------------------------------
module array_list_insert_delete #(
    parameter int DEPTH = alid_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    alid_cmd_if.sink    i_cmd,
    alid_rsp_if.source  o_rsp
);
    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > alid_pkg::POS_W) ? CW : alid_pkg::POS_W;

    localparam logic [CW-1:0]   CNT_MAX = CW'(DEPTH);
    localparam logic [CW-1:0]   ONE     = CW'(1);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INS_RD = 4'd1;
    localparam logic [3:0] S_INS_WR = 4'd2;
    localparam logic [3:0] S_PUT    = 4'd3;
    localparam logic [3:0] S_DEL_RD = 4'd4;
    localparam logic [3:0] S_DEL_WR = 4'd5;
    localparam logic [3:0] S_DMP_RD = 4'd6;
    localparam logic [3:0] S_DMP_LD = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]                      r_state, n_state;
    logic [CW-1:0]                   r_cnt, n_cnt;
    logic [CW-1:0]                   r_idx, n_idx;
    logic [CW-1:0]                   r_pos, n_pos;
    logic [alid_pkg::BYTE_W-1:0]     r_byte, n_byte;
    logic [alid_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [alid_pkg::BYTE_W-1:0]     r_entry, n_entry;
    logic                            r_ev, n_ev;
    logic                            r_last, n_last;

    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [alid_pkg::BYTE_W-1:0]     ram_wdata;
    logic [AW-1:0]                   ram_raddr;
    logic [alid_pkg::BYTE_W-1:0]     ram_rdata;

    logic [CMPW-1:0]                 pos_x;
    logic [CMPW-1:0]                 cnt_x;
    logic [CW-1:0]                   idx_inc;
    logic [CW-1:0]                   idx_dec;
    logic [CW-1:0]                   cnt_dec;

    alid_ram #(
        .WIDTH (alid_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared index arithmetic
    assign pos_x   = CMPW'(i_cmd.position);
    assign cnt_x   = CMPW'(r_cnt);
    assign idx_inc = r_idx + ONE;
    assign idx_dec = r_idx - ONE;
    assign cnt_dec = r_cnt - ONE;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_byte    = r_byte;
        n_status  = r_status;
        n_entry   = r_entry;
        n_ev      = r_ev;
        n_last    = r_last;
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_byte  = i_cmd.data_byte;
                    n_entry = '0;
                    n_ev    = 1'b0;
                    n_last  = 1'b1;
                    unique case (i_cmd.func)
                        alid_pkg::FN_APPEND: begin
                            if (r_cnt >= CNT_MAX) begin
                                n_status = alid_pkg::ST_FULL;
                                n_state  = S_OUT;
                            end else begin
                                n_idx   = r_cnt;
                                n_pos   = r_cnt;
                                n_state = S_INS_RD;
                            end
                        end
                        alid_pkg::FN_INSERT: begin
                            if (r_cnt >= CNT_MAX) begin
                                n_status = alid_pkg::ST_FULL;
                                n_state  = S_OUT;
                            end else if (pos_x > cnt_x) begin
                                n_status = alid_pkg::ST_BADPOS;
                                n_state  = S_OUT;
                            end else begin
                                n_idx   = r_cnt;
                                n_pos   = CW'(pos_x);
                                n_state = S_INS_RD;
                            end
                        end
                        alid_pkg::FN_DEL_AT: begin
                            if (pos_x >= cnt_x) begin
                                n_status = alid_pkg::ST_BADPOS;
                                n_state  = S_OUT;
                            end else begin
                                n_idx   = CW'(pos_x);
                                n_state = S_DEL_RD;
                            end
                        end
                        alid_pkg::FN_DEL_LAST: begin
                            if (r_cnt == '0) begin
                                n_status = alid_pkg::ST_EMPTY;
                                n_state  = S_OUT;
                            end else begin
                                n_idx   = cnt_dec;
                                n_state = S_DEL_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                // Move entries up until the insert slot is free
                ram_raddr = idx_dec[AW-1:0];
                if (r_idx > r_pos) begin
                    n_state = S_INS_WR;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_INS_WR: begin
                ram_we  = 1'b1;
                n_idx   = idx_dec;
                n_state = S_INS_RD;
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[AW-1:0];
                ram_wdata = r_byte;
                n_cnt     = r_cnt + ONE;
                n_idx     = '0;
                n_state   = S_DMP_RD;
            end
            S_DEL_RD: begin
                // Move later entries down over the deleted one
                ram_raddr = idx_inc[AW-1:0];
                if (idx_inc < r_cnt) begin
                    n_state = S_DEL_WR;
                end else begin
                    n_cnt = cnt_dec;
                    n_idx = '0;
                    if (cnt_dec == '0) begin
                        n_status = alid_pkg::ST_OK;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_DMP_RD;
                    end
                end
            end
            S_DEL_WR: begin
                ram_we  = 1'b1;
                n_idx   = idx_inc;
                n_state = S_DEL_RD;
            end
            S_DMP_RD: begin
                n_state = S_DMP_LD;
            end
            S_DMP_LD: begin
                n_status = alid_pkg::ST_OK;
                n_entry  = ram_rdata;
                n_ev     = 1'b1;
                n_last   = (idx_inc == r_cnt);
                n_state  = S_OUT;
            end
            S_OUT: begin
                // Hold the beat until taken, then advance the dump
                if (o_rsp.ready) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = idx_inc;
                        n_state = S_DMP_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_byte   <= n_byte;
        r_status <= n_status;
        r_entry  <= n_entry;
        r_ev     <= n_ev;
        r_last   <= n_last;
    end

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = (r_state == S_OUT);
    assign o_rsp.status      = r_status;
    assign o_rsp.length      = r_cnt;
    assign o_rsp.entry       = r_entry;
    assign o_rsp.entry_valid = r_ev;
    assign o_rsp.last        = r_last;
endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for array_list_insert_delete. Commands go in through a
// queue-fed driver. A shadow list predicts each status beat or list dump. A
// monitor compares every response beat, field by field, with the oldest
// expected beat. Both sides idle in random bursts until the closing stretch.
// ----------------------------------------------------------------------------
module testbench;
    import alid_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int LEN_W        = $clog2(DEPTH + 1);
    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_CMDS  = 500;
    localparam int QUIET_TAIL   = 60;
    localparam int SETTLE_CYC   = 200;
    localparam int LIMIT_CYCLES = 1_000_000;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  position;
        bit                wait_drain;
    } list_cmd_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    length;
        logic [BYTE_W-1:0]   entry;
        logic                entry_valid;
        logic                last;
    } dump_beat_t;

    logic clk;
    logic rst_n;

    alid_cmd_if                 cmd_if ();
    alid_rsp_if #(.DEPTH(DEPTH)) rsp_if ();

    array_list_insert_delete #(.DEPTH(DEPTH)) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    list_cmd_t   cmd_backlog[$];
    dump_beat_t  expected_dump[$];
    list_cmd_t   cmd_on_bus;

    logic [BYTE_W-1:0] shadow_bytes[DEPTH];
    int                shadow_len;
    int                gen_len;

    int   cmds_total;
    int   cmds_accepted;
    int   mismatch_cnt;
    int   idle_pct;
    bit   quiet;
    int   cmd_gap_left;
    int   rsp_stall_left;

    // Clock
    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard limit on run time
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow list
    // ------------------------------------------------------------------------

    // Shift up and place a byte, or report why not
    function automatic logic [STATUS_W-1:0] shadow_insert(int pos, logic [BYTE_W-1:0] b);
        if (shadow_len >= DEPTH)
            return ST_FULL;
        if (pos > shadow_len)
            return ST_BADPOS;
        for (int i = shadow_len; i > pos; i--)
            shadow_bytes[i] = shadow_bytes[i-1];
        shadow_bytes[pos] = b;
        shadow_len++;
        return ST_OK;
    endfunction

    // Shift down over the removed place and clear the vacated top
    function automatic logic [STATUS_W-1:0] shadow_remove(int pos);
        if (pos >= shadow_len)
            return ST_BADPOS;
        for (int i = pos; i + 1 < shadow_len; i++)
            shadow_bytes[i] = shadow_bytes[i+1];
        shadow_len--;
        shadow_bytes[shadow_len] = '0;
        return ST_OK;
    endfunction

    // Apply one accepted command and queue the beats it must produce
    task automatic apply_list_cmd(list_cmd_t c);
        logic [STATUS_W-1:0] st;
        dump_beat_t          b;
        case (c.func)
            FN_APPEND: st = shadow_insert(shadow_len, c.data_byte);
            FN_INSERT: st = shadow_insert(int'(c.position), c.data_byte);
            FN_DEL_AT: st = shadow_remove(int'(c.position));
            default:   st = (shadow_len == 0) ? ST_EMPTY : shadow_remove(shadow_len - 1);
        endcase
        b.length = LEN_W'(shadow_len);
        if (st != ST_OK || shadow_len == 0) begin
            b.status      = st;
            b.entry       = '0;
            b.entry_valid = 1'b0;
            b.last        = 1'b1;
            expected_dump.push_back(b);
        end else begin
            for (int i = 0; i < shadow_len; i++) begin
                b.status      = ST_OK;
                b.entry       = shadow_bytes[i];
                b.entry_valid = 1'b1;
                b.last        = (i + 1 == shadow_len);
                expected_dump.push_back(b);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------

    // Queue a command and track the length it leaves behind
    task automatic queue_cmd(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b,
                             logic [POS_W-1:0] p, bit drain = 1'b0);
        list_cmd_t c;
        c.func       = f;
        c.data_byte  = b;
        c.position   = p;
        c.wait_drain = drain;
        cmd_backlog.push_back(c);
        case (f)
            FN_APPEND: if (gen_len < DEPTH) gen_len++;
            FN_INSERT: if (gen_len < DEPTH && int'(p) <= gen_len) gen_len++;
            FN_DEL_AT: if (int'(p) < gen_len) gen_len--;
            default:   if (gen_len > 0) gen_len--;
        endcase
    endtask

    // Random byte, leaning on the extremes now and then
    function automatic logic [BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 8'h00;
        if (r < 10)
            return 8'hFF;
        return BYTE_W'($urandom);
    endfunction

    initial begin
        int  r;
        bit  grow;
        logic [FUNC_W-1:0] f;
        logic [POS_W-1:0]  p;

        // Known values on every input from time zero
        rst_n            = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.func      = FN_APPEND;
        cmd_if.data_byte = '0;
        cmd_if.position  = '0;
        rsp_if.ready     = 1'b0;
        gen_len          = 0;

        // Directed: empty list failures
        queue_cmd(FN_DEL_LAST, 8'h00, 4'd0);
        queue_cmd(FN_DEL_AT,   8'h00, 4'd0);
        queue_cmd(FN_INSERT,   8'hFF, 4'd1);
        // Insert at front, at the length, and in the middle
        queue_cmd(FN_INSERT,   8'h00, 4'd0);
        queue_cmd(FN_INSERT,   8'hFF, 4'd1);
        queue_cmd(FN_INSERT,   8'hA5, 4'd1);
        // Positions just past the valid range
        queue_cmd(FN_INSERT,   8'h3C, 4'd4);
        queue_cmd(FN_DEL_AT,   8'h00, 4'd3);
        // Delete the stored zero byte
        queue_cmd(FN_DEL_AT,   8'h00, 4'd0);
        // Fill to capacity, then push against the full list
        while (gen_len < DEPTH)
            queue_cmd(FN_APPEND, (gen_len % 2) ? 8'hFF : 8'h00, 4'd0);
        queue_cmd(FN_APPEND,   8'h5A, 4'd0, 1'b1);
        queue_cmd(FN_INSERT,   8'h5A, 4'd15);
        // Top position on a full list, then insert at the length
        queue_cmd(FN_DEL_AT,   8'h00, 4'd15);
        queue_cmd(FN_INSERT,   8'h81, 4'd15);

        // Random: alternate growing and shrinking phases so the length sweeps
        for (int k = 0; k < RANDOM_CMDS; k++) begin
            grow = ((k / 40) % 2) == 0;
            r = $urandom_range(0, 99);
            if (grow)
                f = (r < 35) ? FN_APPEND : (r < 70) ? FN_INSERT :
                    (r < 85) ? FN_DEL_AT : FN_DEL_LAST;
            else
                f = (r < 15) ? FN_APPEND : (r < 30) ? FN_INSERT :
                    (r < 65) ? FN_DEL_AT : FN_DEL_LAST;
            if ($urandom_range(0, 99) < 10)
                p = POS_W'($urandom);
            else if (f == FN_INSERT)
                p = POS_W'($urandom_range(0, (gen_len < DEPTH) ? gen_len : DEPTH - 1));
            else if (f == FN_DEL_AT && gen_len > 0)
                p = POS_W'($urandom_range(0, gen_len - 1));
            else
                p = POS_W'($urandom);
            queue_cmd(f, pick_byte(), p, (k == 150 || k == 350));
        end
        cmds_total = cmd_backlog.size();

        // Reset
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait out the stimulus, the outstanding beats, then a settle time
        while (cmds_accepted < cmds_total)
            @(posedge clk);
        while (expected_dump.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        if (mismatch_cnt == 0 && expected_dump.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_if.valid  <= 1'b0;
            cmd_gap_left  <= 0;
            cmds_accepted <= 0;
            idle_pct      <= 20;
            quiet         <= 1'b0;
            shadow_len    <= 0;
            for (int i = 0; i < DEPTH; i++)
                shadow_bytes[i] <= '0;
        end else begin
            // Predict on each accepted beat; reshuffle idle rate now and then
            if (cmd_if.valid && cmd_if.ready) begin
                apply_list_cmd(cmd_on_bus);
                cmds_accepted <= cmds_accepted + 1;
                if (cmds_accepted % 40 == 0)
                    case ($urandom_range(0, 3))
                        0:       idle_pct <= 0;
                        1:       idle_pct <= 10;
                        2:       idle_pct <= 25;
                        default: idle_pct <= 50;
                    endcase
            end
            quiet <= (cmd_backlog.size() < QUIET_TAIL);

            // Hold the beat while it is not taken, else idle or present the next
            if (cmd_if.valid && !cmd_if.ready) begin
            end else if (cmd_gap_left != 0) begin
                cmd_if.valid <= 1'b0;
                cmd_gap_left <= cmd_gap_left - 1;
            end else if (cmd_backlog.size() == 0) begin
                cmd_if.valid <= 1'b0;
            end else if (cmd_backlog[0].wait_drain && expected_dump.size() != 0) begin
                cmd_if.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                cmd_if.valid <= 1'b0;
                cmd_gap_left <= $urandom_range(0, 18);
            end else begin
                cmd_on_bus        = cmd_backlog.pop_front();
                cmd_if.valid     <= 1'b1;
                cmd_if.func      <= cmd_on_bus.func;
                cmd_if.data_byte <= cmd_on_bus.data_byte;
                cmd_if.position  <= cmd_on_bus.position;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        dump_beat_t want;
        if (!rst_n) begin
            rsp_if.ready   <= 1'b0;
            rsp_stall_left <= 0;
            mismatch_cnt   <= 0;
        end else begin
            // Compare each taken beat with the oldest expectation
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_dump.size() == 0) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("unexpected beat: status=%0d length=%0d entry=%02h",
                                 rsp_if.status, rsp_if.length, rsp_if.entry,
                                 " ev=%0b last=%0b",
                                 rsp_if.entry_valid, rsp_if.last);
                end else begin
                    want = expected_dump.pop_front();
                    if (rsp_if.status !== want.status || rsp_if.length !== want.length ||
                        rsp_if.entry !== want.entry || rsp_if.entry_valid !== want.entry_valid ||
                        rsp_if.last !== want.last) begin
                        mismatch_cnt <= mismatch_cnt + 1;
                        if (mismatch_cnt < 10) begin
                            $write("mismatch: expected status=%0d length=%0d entry=%02h ",
                                   want.status, want.length, want.entry);
                            $write("ev=%0b last=%0b, got status=%0d length=%0d ",
                                   want.entry_valid, want.last,
                                   rsp_if.status, rsp_if.length);
                            $display("entry=%02h ev=%0b last=%0b",
                                     rsp_if.entry, rsp_if.entry_valid, rsp_if.last);
                        end
                    end
                end
            end

            // Stall in random bursts, starting none in the closing stretch
            if (rsp_stall_left != 0) begin
                rsp_if.ready   <= 1'b0;
                rsp_stall_left <= rsp_stall_left - 1;
            end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                rsp_if.ready   <= 1'b0;
                rsp_stall_left <= $urandom_range(0, 18);
            end else begin
                rsp_if.ready   <= 1'b1;
            end
        end
    end

endmodule
